[src/text_glyph_renderer_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef TEXT_GLYPH_RENDERER_UNIT_ASSERT_SVH
`define TEXT_GLYPH_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/tgr_pkg.sv]
package tgr_pkg;

	localparam int ScreenWidthDefault  = 128;
	localparam int ScreenHeightDefault = 160;

	localparam int GlyphCols = 5;
	localparam int GlyphRows = 7;
	localparam int SpacerCol = 5;
	localparam int LastRow   = 6;
	localparam int CellStep  = 6;
	localparam int LineStep  = 8;

	localparam logic [15:0] TextColorReset = 16'hFFFF;
	localparam logic [15:0] BackColorReset = 16'h0000;

	typedef enum logic [0:0] {
		RegTextColor = 1'b0,
		RegBackColor = 1'b1
	} cfg_reg_t;

	// Column-major glyph, bit 0 of each column is the top row.
	typedef logic [GlyphCols-1:0][GlyphRows-1:0] glyph_t;

	typedef struct packed {
		glyph_t      glyph;
		logic [10:0] col;
		logic [10:0] row;
		logic [2:0]  c_last;
		logic [2:0]  r_last;
	} cmd_t;

	localparam int RomDepth = 39;
	localparam logic [5:0] IdxLetterBase = 6'd10;
	localparam logic [5:0] IdxColon      = 6'd36;
	localparam logic [5:0] IdxDash       = 6'd37;
	localparam logic [5:0] IdxDot        = 6'd38;

	localparam logic [7:0] CharZero   = 8'h30;
	localparam logic [7:0] CharNine   = 8'h39;
	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperZ = 8'h5A;
	localparam logic [7:0] CharLowerA = 8'h61;
	localparam logic [7:0] CharLowerZ = 8'h7A;
	localparam logic [7:0] CharColon  = 8'h3A;
	localparam logic [7:0] CharDash   = 8'h2D;
	localparam logic [7:0] CharDot    = 8'h2E;
	localparam logic [7:0] CaseOffset = 8'h20;

	localparam logic [7:0] GlyphRom [RomDepth][GlyphCols] = '{
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
		'{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
		'{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
		'{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
		'{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
		'{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
		'{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
		'{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
		'{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
		'{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
		'{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
		'{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
		'{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
		'{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
		'{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}
	};

	// Fold lower case, map the code to a ROM row; unknown codes give a blank glyph.
	function automatic glyph_t glyph_lookup(input logic [7:0] code);
		logic [7:0] folded;
		logic [5:0] idx;
		logic       known;
		glyph_t     g;
		folded = code;
		if (code inside {[CharLowerA:CharLowerZ]}) begin
			folded = code - CaseOffset;
		end
		idx   = '0;
		known = 1'b1;
		case (folded) inside
			[CharZero:CharNine]:     idx = 6'(folded - CharZero);
			[CharUpperA:CharUpperZ]: idx = 6'(folded - CharUpperA) + IdxLetterBase;
			CharColon:               idx = IdxColon;
			CharDash:                idx = IdxDash;
			CharDot:                 idx = IdxDot;
			default:                 known = 1'b0;
		endcase
		g    = '0;
		g[0] = GlyphRom[idx][0][GlyphRows-1:0];
		g[1] = GlyphRom[idx][1][GlyphRows-1:0];
		g[2] = GlyphRom[idx][2][GlyphRows-1:0];
		g[3] = GlyphRom[idx][3][GlyphRows-1:0];
		g[4] = GlyphRom[idx][4][GlyphRows-1:0];
		if (!known) begin
			g = '0;
		end
		return g;
	endfunction

endpackage

[src/tgr_front.sv]
module tgr_front #(
	parameter int SCREEN_WIDTH  = tgr_pkg::ScreenWidthDefault,
	parameter int SCREEN_HEIGHT = tgr_pkg::ScreenHeightDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  logic           restart,
	input  logic [9:0]     start_x,
	input  logic [9:0]     start_y,
	input  logic [7:0]     char_code,
	output logic           cmd_push,
	output tgr_pkg::cmd_t  cmd
);

	localparam logic [11:0] Width12  = 12'(SCREEN_WIDTH);
	localparam logic [11:0] Height12 = 12'(SCREEN_HEIGHT);

	logic [10:0] cursor_col_q;
	logic [10:0] cursor_row_q;
	logic        halted_q;

	logic        accept;
	logic [10:0] base_col;
	logic [10:0] base_row;
	logic        halt_eff;
	logic [11:0] col12;
	logic [11:0] row12;
	logic        visible;
	logic [11:0] avail_col;
	logic [11:0] avail_row;
	logic [10:0] next_col;
	logic        wrap;
	logic [10:0] new_col;
	logic [10:0] new_row;
	logic        halt_next;

	assign accept   = push && !full;
	assign base_col = restart ? {1'b0, start_x} : cursor_col_q;
	assign base_row = restart ? {1'b0, start_y} : cursor_row_q;
	assign halt_eff = restart ? 1'b0 : halted_q;

	assign col12     = {1'b0, base_col};
	assign row12     = {1'b0, base_row};
	assign visible   = (col12 < Width12) && (row12 < Height12);
	assign avail_col = Width12 - 12'd1 - col12;
	assign avail_row = Height12 - 12'd1 - row12;

	// Cursor step with wrap to the next text line.
	assign next_col  = base_col + 11'(tgr_pkg::CellStep);
	assign wrap      = ({1'b0, next_col} + 12'(tgr_pkg::GlyphCols)) >= Width12;
	assign new_col   = wrap ? '0 : next_col;
	assign new_row   = wrap ? base_row + 11'(tgr_pkg::LineStep) : base_row;
	assign halt_next = ({1'b0, new_row} + 12'(tgr_pkg::GlyphRows)) >= Height12;

	always_comb begin
		cmd.glyph  = tgr_pkg::glyph_lookup(char_code);
		cmd.col    = base_col;
		cmd.row    = base_row;
		cmd.c_last = (avail_col >= 12'(tgr_pkg::SpacerCol)) ? 3'(tgr_pkg::SpacerCol)
			: avail_col[2:0];
		cmd.r_last = (avail_row >= 12'(tgr_pkg::LastRow)) ? 3'(tgr_pkg::LastRow)
			: avail_row[2:0];
	end

	// Fully clipped cells still move the cursor but send no work downstream.
	assign cmd_push = accept && !halt_eff && visible;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			halted_q     <= 1'b0;
		end else if (accept && !halt_eff) begin
			cursor_col_q <= new_col;
			cursor_row_q <= new_row;
			halted_q     <= halt_next;
		end
	end

endmodule

[src/tgr_cmd_fifo.sv]
module tgr_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tgr_pkg::cmd_t  wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output tgr_pkg::cmd_t  head,
	output logic           head_valid
);

	localparam int Depth   = 2;
	localparam int PtrW    = $clog2(Depth);
	localparam int CountW  = $clog2(Depth + 1);

	tgr_pkg::cmd_t       mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CountW-1:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full       = (count_q == CountW'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_wr      = wr_en && !full;
	assign do_rd      = rd_en && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CountW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CountW'(1);
			end
		end
	end

endmodule

[src/tgr_back.sv]
module tgr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  tgr_pkg::cmd_t  head,
	input  logic           head_valid,
	output logic           head_pop,
	output logic           empty,
	input  logic           pop,
	output logic [9:0]     pixel_x,
	output logic [9:0]     pixel_y,
	output logic [15:0]    pixel_color,
	output logic           last_pixel
);

	logic [15:0] text_color_q;
	logic [15:0] back_color_q;
	logic [2:0]  c_q;
	logic [2:0]  r_q;
	logic        out_valid_q;

	logic                        adv;
	logic                        emit;
	logic                        is_last;
	logic [tgr_pkg::GlyphRows-1:0] col_bits;
	logic                        pix_on;
	logic [10:0]                 sum_x;
	logic [10:0]                 sum_y;

	assign adv      = !out_valid_q || pop;
	assign emit     = adv && head_valid;
	assign is_last  = (c_q == head.c_last) && (r_q == head.r_last);
	assign head_pop = emit && is_last;
	assign empty    = !out_valid_q;

	assign col_bits = (c_q == 3'(tgr_pkg::SpacerCol)) ? '0 : head.glyph[c_q];
	assign pix_on   = col_bits[r_q];
	assign sum_x    = head.col + {8'b0, c_q};
	assign sum_y    = head.row + {8'b0, r_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tgr_pkg::TextColorReset;
			back_color_q <= tgr_pkg::BackColorReset;
		end else if (cfg_we) begin
			case (tgr_pkg::cfg_reg_t'(cfg_index))
				tgr_pkg::RegTextColor: text_color_q <= cfg_data;
				tgr_pkg::RegBackColor: back_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Walk the visible part of the cell, rows inside columns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q         <= '0;
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				if (is_last) begin
					c_q <= '0;
					r_q <= '0;
				end else if (r_q == head.r_last) begin
					c_q <= c_q + 3'd1;
					r_q <= '0;
				end else begin
					r_q <= r_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x     <= sum_x[9:0];
			pixel_y     <= sum_y[9:0];
			pixel_color <= pix_on ? text_color_q : back_color_q;
			last_pixel  <= is_last;
		end
	end

endmodule

[src/text_glyph_renderer_unit.sv]
// Channel   Handshake              Payload
// input     push / full            restart, start_x, start_y, char_code
// result    empty / pop            pixel_x, pixel_y, pixel_color, last_pixel
// config    cfg_we                 cfg_index, cfg_data
//
// The pixel walker emits one pixel per cycle unless the result is stalled: a character
// yields each visible pixel of its 6x7 cell, 42 at most, none when fully clipped or halted.
// On an idle block a character is first written to the command queue, then its first
// pixel is registered onto the result ports, where it can transfer.
// A two-entry command queue lets the front take characters while pixels drain.
// Reset clears cursor, halt flag, queue and output valid, and restores colors.
module text_glyph_renderer_unit #(
	parameter int SCREEN_WIDTH  = tgr_pkg::ScreenWidthDefault,
	parameter int SCREEN_HEIGHT = tgr_pkg::ScreenHeightDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        restart,
	input  logic [9:0]  start_x,
	input  logic [9:0]  start_y,
	input  logic [7:0]  char_code,
	output logic        empty,
	input  logic        pop,
	output logic [9:0]  pixel_x,
	output logic [9:0]  pixel_y,
	output logic [15:0] pixel_color,
	output logic        last_pixel,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tgr_pkg::cmd_t front_cmd;
	tgr_pkg::cmd_t head_cmd;
	logic          front_push;
	logic          head_valid;
	logic          head_pop;

	tgr_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.restart  (restart),
		.start_x  (start_x),
		.start_y  (start_y),
		.char_code(char_code),
		.cmd_push (front_push),
		.cmd      (front_cmd)
	);

	tgr_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_push),
		.wr_cmd    (front_cmd),
		.full      (full),
		.rd_en     (head_pop),
		.head      (head_cmd),
		.head_valid(head_valid)
	);

	tgr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head       (head_cmd),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel)
	);

endmodule

[src/tgr_checker.sv]
`include "text_glyph_renderer_unit_assert.svh"

module tgr_checker #(
	parameter int SCREEN_WIDTH  = tgr_pkg::ScreenWidthDefault,
	parameter int SCREEN_HEIGHT = tgr_pkg::ScreenHeightDefault
) (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [9:0]  pixel_x,
	input logic [9:0]  pixel_y,
	input logic [15:0] pixel_color,
	input logic        last_pixel
);

	localparam logic [10:0] Width11  = 11'(SCREEN_WIDTH);
	localparam logic [10:0] Height11 = 11'(SCREEN_HEIGHT);

	logic xfer_out;
	assign xfer_out = pop && !empty;

	`TGR_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop,
		!empty && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color)
		&& $stable(last_pixel), "stalled result changed")

	`TGR_ASSERT_IMPL(a_on_screen, clk, arst_n, !empty,
		({1'b0, pixel_x} < Width11) && ({1'b0, pixel_y} < Height11),
		"pixel outside the screen")

	`TGR_ASSERT_NEXT(a_cell_continues, clk, arst_n, xfer_out && !last_pixel,
		!empty, "gap inside a character")

	// A cell clipped to its top row steps across with the row unchanged.
	`TGR_ASSERT_NEXT(a_cell_order, clk, arst_n, xfer_out && !last_pixel,
		(pixel_x == $past(pixel_x) && pixel_y == $past(pixel_y) + 10'd1)
		|| (pixel_x == $past(pixel_x) + 10'd1 && pixel_y <= $past(pixel_y)),
		"pixels of a character out of order")

endmodule

bind text_glyph_renderer_unit tgr_checker #(
	.SCREEN_WIDTH (SCREEN_WIDTH),
	.SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tgr_checker (.*);

[tb/tb.sv]
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ScrW         = 128;
	localparam int ScrH         = 160;
	localparam int SettleCycles = 24;
	localparam int IdleLimit    = 5000;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [15:0] color;
		logic        last;
	} pixel_t;

	typedef struct packed {
		logic       rs;
		logic [9:0] sx;
		logic [9:0] sy;
		logic [7:0] code;
		int         pix_n;   // typed pixel count, -1 when left to the predictor
	} char_row_t;

	localparam int ScriptLen = 23;
	localparam char_row_t Script [ScriptLen] = '{
		'{1'b0, 10'd0,    10'd0,    "8",   42},  // cursor at home after reset
		'{1'b0, 10'd0,    10'd0,    "a",   42},  // lower case folds
		'{1'b0, 10'd0,    10'd0,    ":",   42},
		'{1'b0, 10'd0,    10'd0,    "-",   42},
		'{1'b0, 10'd0,    10'd0,    ".",   42},
		'{1'b0, 10'd0,    10'd0,    8'h00, 42},  // blank glyph
		'{1'b0, 10'd0,    10'd0,    8'hFF, 42},
		'{1'b0, 10'd0,    10'd0,    8'h80, 42},
		'{1'b1, 10'd0,    10'd0,    "Z",   42},
		'{1'b0, 10'd1023, 10'd1023, "z",   42},  // start fields ignored without restart
		'{1'b1, 10'd125,  10'd0,    "W",   21},  // clipped at right edge, then wrap
		'{1'b0, 10'd0,    10'd0,    "0",   42},
		'{1'b1, 10'd122,  10'd40,   "9",   42},
		'{1'b1, 10'd1023, 10'd0,    "5",   0},   // fully off screen, still advances
		'{1'b0, 10'd0,    10'd0,    "7",   42},
		'{1'b1, 10'd0,    10'd155,  "R",   30},  // clipped at bottom, then halt
		'{1'b0, 10'd0,    10'd0,    "Q",   0},   // halted
		'{1'b1, 10'd127,  10'd159,  "#",   1},   // single corner pixel
		'{1'b1, 10'd1023, 10'd1023, "M",   0},   // start below the bottom
		'{1'b0, 10'd0,    10'd0,    "X",   0},
		'{1'b1, 10'd0,    10'd153,  "K",   42},
		'{1'b1, 10'd120,  10'd150,  "E",   42},
		'{1'b1, 10'd0,    10'd0,    "m",   42}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        restart   = 1'b0;
	logic [9:0]  start_x   = '0;
	logic [9:0]  start_y   = '0;
	logic [7:0]  char_code = '0;
	logic        pop       = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	wire         full;
	wire         empty;
	wire  [9:0]  pixel_x;
	wire  [9:0]  pixel_y;
	wire  [15:0] pixel_color;
	wire         last_pixel;

	text_glyph_renderer_unit #(
		.SCREEN_WIDTH (ScrW),
		.SCREEN_HEIGHT(ScrH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.restart    (restart),
		.start_x    (start_x),
		.start_y    (start_y),
		.char_code  (char_code),
		.empty      (empty),
		.pop        (pop),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state
	logic [15:0] paint_fg    = 16'hFFFF;
	logic [15:0] paint_bg    = 16'h0000;
	logic [10:0] cur_col     = '0;
	logic [10:0] cur_row     = '0;
	logic        text_halted = 1'b0;
	int          cell_pixels;
	pixel_t      pixels_due[$];

	int     mismatches  = 0;
	int     chars_taken = 0;
	int     idle_cycles = 0;
	int     send_idle   = 0;
	int     pop_idle    = 0;
	bit     moved;
	pixel_t got_px;
	pixel_t want_px;
	string  glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz:-.";

	// Columns 0..4 packed with column 0 in the top byte; bit 0 is the top row.
	function automatic logic [39:0] glyph_of(input logic [7:0] code);
		logic [7:0]  ch;
		logic [39:0] g;
		ch = (code >= "a" && code <= "z") ? code - 8'h20 : code;
		case (ch)
			"0": g = 40'h3E_51_49_45_3E;
			"1": g = 40'h00_42_7F_40_00;
			"2": g = 40'h42_61_51_49_46;
			"3": g = 40'h21_41_45_4B_31;
			"4": g = 40'h18_14_12_7F_10;
			"5": g = 40'h27_45_45_45_39;
			"6": g = 40'h3C_4A_49_49_30;
			"7": g = 40'h01_71_09_05_03;
			"8": g = 40'h36_49_49_49_36;
			"9": g = 40'h06_49_49_29_1E;
			"A": g = 40'h7E_11_11_11_7E;
			"B": g = 40'h7F_49_49_49_36;
			"C": g = 40'h3E_41_41_41_22;
			"D": g = 40'h7F_41_41_22_1C;
			"E": g = 40'h7F_49_49_49_41;
			"F": g = 40'h7F_09_09_09_01;
			"G": g = 40'h3E_41_49_49_7A;
			"H": g = 40'h7F_08_08_08_7F;
			"I": g = 40'h00_41_7F_41_00;
			"J": g = 40'h20_40_41_3F_01;
			"K": g = 40'h7F_08_14_22_41;
			"L": g = 40'h7F_40_40_40_40;
			"M": g = 40'h7F_02_0C_02_7F;
			"N": g = 40'h7F_04_08_10_7F;
			"O": g = 40'h3E_41_41_41_3E;
			"P": g = 40'h7F_09_09_09_06;
			"Q": g = 40'h3E_41_51_21_5E;
			"R": g = 40'h7F_09_19_29_46;
			"S": g = 40'h46_49_49_49_31;
			"T": g = 40'h01_01_7F_01_01;
			"U": g = 40'h3F_40_40_40_3F;
			"V": g = 40'h1F_20_40_20_1F;
			"W": g = 40'h7F_20_18_20_7F;
			"X": g = 40'h63_14_08_14_63;
			"Y": g = 40'h07_08_70_08_07;
			"Z": g = 40'h61_51_49_45_43;
			":": g = 40'h00_36_36_00_00;
			"-": g = 40'h08_08_08_08_08;
			".": g = 40'h00_60_60_00_00;
			default: g = '0;
		endcase
		return g;
	endfunction

	// Queue the visible pixels of one character cell and move the cursor.
	task automatic draw_glyph_cell(input logic rs, input logic [9:0] sx, input logic [9:0] sy,
			input logic [7:0] code);
		logic [39:0] g;
		logic [7:0]  colbits;
		pixel_t      p;
		pixel_t      held;
		bit          have_held;
		int          n;
		int          px;
		int          py;
		n         = 0;
		have_held = 1'b0;
		if (rs) begin
			cur_col     = {1'b0, sx};
			cur_row     = {1'b0, sy};
			text_halted = 1'b0;
		end
		if (!text_halted) begin
			g = glyph_of(code);
			for (int c = 0; c < 6; c++) begin
				colbits = (c < 5) ? g[39 - 8 * c -: 8] : 8'h00;
				for (int r = 0; r < 7; r++) begin
					px = int'(cur_col) + c;
					py = int'(cur_row) + r;
					if (px < ScrW && py < ScrH) begin
						p.x     = px[9:0];
						p.y     = py[9:0];
						p.color = colbits[r] ? paint_fg : paint_bg;
						p.last  = 1'b0;
						// hold back one pixel so the final one can be flagged
						if (have_held)
							pixels_due.push_back(held);
						held      = p;
						have_held = 1'b1;
						n++;
					end
				end
			end
			if (have_held) begin
				held.last = 1'b1;
				pixels_due.push_back(held);
			end
			cur_col = cur_col + 11'd6;
			if (int'(cur_col) + 5 >= ScrW) begin
				cur_col = '0;
				cur_row = cur_row + 11'd8;
			end
			if (int'(cur_row) + 7 >= ScrH)
				text_halted = 1'b1;
		end
		cell_pixels = n;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we) begin
				if (cfg_index == tgr_pkg::RegTextColor)
					paint_fg = cfg_data;
				else
					paint_bg = cfg_data;
				moved = 1'b1;
			end
			if (push && !full) begin
				draw_glyph_cell(restart, start_x, start_y, char_code);
				chars_taken++;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				got_px = {pixel_x, pixel_y, pixel_color, last_pixel};
				moved  = 1'b1;
				if (pixels_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
						$time, pixel_x, pixel_y, pixel_color, last_pixel);
				end else begin
					want_px = pixels_due.pop_front();
					if (got_px !== want_px) begin
						mismatches++;
						$display("%0t: exp x=%0d y=%0d c=%h l=%b got x=%0d y=%0d c=%h l=%b",
							$time, want_px.x, want_px.y, want_px.color, want_px.last,
							got_px.x, got_px.y, got_px.color, got_px.last);
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, IdleLimit);
				$display("FAIL text_glyph_renderer_unit");
				$finish;
			end
		end
	end

	always @(negedge clk)
		pop <= ($urandom_range(0, 99) >= pop_idle);

	// Entered and left at a falling edge; push stays high on return.
	task automatic send_char(input logic rs, input logic [9:0] sx, input logic [9:0] sy,
			input logic [7:0] code);
		int seen;
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		restart   <= rs;
		start_x   <= sx;
		start_y   <= sy;
		char_code <= code;
		seen = chars_taken;
		do
			@(negedge clk);
		while (chars_taken == seen);
	endtask

	// Hold off until every pixel is out, then give zero-pixel work time to clear.
	task automatic settle();
		push <= 1'b0;
		while (pixels_due.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input tgr_pkg::cfg_reg_t idx, input logic [15:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int n_chars, input int tx_gap, input int rx_gap);
		int         sent;
		logic       rs;
		logic [9:0] sx;
		logic [9:0] sy;
		logic [7:0] code;
		sent      = 0;
		send_idle = tx_gap;
		pop_idle  = rx_gap;
		while (sent < n_chars) begin
			rs = ($urandom_range(0, 99) < 8);
			sx = 10'($urandom_range(0, 1023));
			sy = 10'($urandom_range(0, 1023));
			if (rs && $urandom_range(0, 3) != 0) begin
				sx = 10'($urandom_range(0, ScrW - 1));
				sy = 10'($urandom_range(0, ScrH - 1));
			end
			if ($urandom_range(0, 99) < 70)
				code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
			else
				code = 8'($urandom_range(0, 255));
			send_char(rs, sx, sy, code);
			sent++;
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 16;
		pop_idle  = 73;
		foreach (Script[i]) begin
			send_char(Script[i].rs, Script[i].sx, Script[i].sy, Script[i].code);
			if (Script[i].pix_n >= 0 && cell_pixels != Script[i].pix_n) begin
				mismatches++;
				$display("%0t: row %0d pixel count exp %0d got %0d",
					$time, i, Script[i].pix_n, cell_pixels);
			end
		end

		settle();
		write_reg(tgr_pkg::RegTextColor, 16'h0000);
		write_reg(tgr_pkg::RegBackColor, 16'hFFFF);
		run_phase(102, 16, 73);

		settle();
		write_reg(tgr_pkg::RegTextColor, 16'($urandom_range(0, 65535)));
		write_reg(tgr_pkg::RegBackColor, 16'($urandom_range(0, 65535)));
		run_phase(102, 73, 16);

		settle();
		write_reg(tgr_pkg::RegTextColor, 16'hFFFF);
		write_reg(tgr_pkg::RegBackColor, 16'($urandom_range(0, 65535)));
		run_phase(102, 0, 0);

		settle();
		if (mismatches == 0)
			$display("PASS text_glyph_renderer_unit");
		else
			$display("FAIL text_glyph_renderer_unit");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/tgr_pkg.sv
src/tgr_front.sv
src/tgr_cmd_fifo.sv
src/tgr_back.sv
src/text_glyph_renderer_unit.sv
src/tgr_checker.sv
tb/tb.sv
